// ===== rtl/core/sssd_pkg.sv =====
package sssd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int POS_W       = 3;
    localparam int DIGIT_W     = 4;
    localparam int VALUE_W     = 14;
    localparam int SEG_W       = 8;
    localparam int PATTERN_W   = 40;
    localparam int PDATA_W     = 64;
    localparam int PADDR_W     = 4;

    localparam logic [VALUE_W-1:0]   MAX_SHOWN          = 14'd9999;
    localparam logic [PATTERN_W-1:0] PATTERNS_LOW_RST   = 40'h664F5B063F;
    localparam logic [PATTERN_W-1:0] PATTERNS_HIGH_RST  = 40'h6F7F077D6D;

    // register index, taken from paddr[3]
    localparam logic REG_PATTERNS_LOW  = 1'b0;
    localparam logic REG_PATTERNS_HIGH = 1'b1;

    typedef enum logic [1:0] {
        OP_SET_VALUE  = 2'd0,
        OP_FRAME_TICK = 2'd1,
        OP_BYTE_DONE  = 2'd2
    } op_t;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef digit_t [DIGIT_COUNT-1:0] digits_t;

    // saturate to 9999, then thousands/hundreds/tens by threshold compare, ones as remainder
    function automatic digits_t split_value(logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] v;
        logic [9:0]         r1;
        logic [6:0]         r2;
        logic [3:0]         r3;
        digit_t             d0;
        digit_t             d1;
        digit_t             d2;
        digits_t            res;
        v  = (value > MAX_SHOWN) ? MAX_SHOWN : value;
        d0 = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (v >= VALUE_W'(k * 1000))
                d0 = DIGIT_W'(k);
        end
        r1 = 10'(v - VALUE_W'(d0) * VALUE_W'(1000));
        d1 = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (r1 >= 10'(k * 100))
                d1 = DIGIT_W'(k);
        end
        r2 = 7'(r1 - 10'(d1) * 10'd100);
        d2 = '0;
        for (int k = 1; k < 10; k++)
        begin
            if (r2 >= 7'(k * 10))
                d2 = DIGIT_W'(k);
        end
        r3 = 4'(r2 - 7'(d2) * 7'd10);
        res[0] = d0;
        res[1] = d1;
        res[2] = d2;
        res[3] = r3;
        return res;
    endfunction

    function automatic logic [SEG_W-1:0] segment_byte(
        digit_t                 digit,
        logic [PATTERN_W-1:0]   pat_low,
        logic [PATTERN_W-1:0]   pat_high
    );
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = pat_low[7:0];
            4'd1:    seg = pat_low[15:8];
            4'd2:    seg = pat_low[23:16];
            4'd3:    seg = pat_low[31:24];
            4'd4:    seg = pat_low[39:32];
            4'd5:    seg = pat_high[7:0];
            4'd6:    seg = pat_high[15:8];
            4'd7:    seg = pat_high[23:16];
            4'd8:    seg = pat_high[31:24];
            4'd9:    seg = pat_high[39:32];
            default: seg = '0;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/core/seven_segment_scan_driver.sv =====
// Four-digit multiplexed seven-segment scan driver.
//
// Input channel (in_valid/in_ready, opcode, value): one word per event.
//   set value  - stores the four decimal digits of value (saturated at 9999),
//                gives no result word.
//   frame tick - restarts the scan and sends digit 0's segment byte.
//   byte done  - pulses the latch line of the current digit and sends the
//                next digit's byte; after the fourth digit it sends no byte and the position returns to 0.
// Output channel (out_valid/out_ready): strobe_valid/strobe_line and
// send_valid/send_byte of one event. Opcode 3 is dropped silently.
// Timing: a word is captured in the input register, processed from there and
// lands in the output register. One word per cycle is sustained while the
// receiver does not stall; the digit split is a three-level compare/subtract
// chain in the single processing stage.
// A stalled receiver holds the output register; the input register still
// takes one more word and in_ready drops only when both are occupied.
// Reset: digits 0,1,2,3, scan position 0, the default segment table,
// both channel stages empty. APB: patterns_low at 0x0, patterns_high at 0x8.
module seven_segment_scan_driver
    import sssd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [VALUE_W-1:0]   value,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 strobe_valid,
    output logic [1:0]           strobe_line,
    output logic                 send_valid,
    output logic [SEG_W-1:0]     send_byte,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // configuration
    logic [PATTERN_W-1:0] pat_low_reg;
    logic [PATTERN_W-1:0] pat_high_reg;

    // input register
    logic                 s1_valid_reg;
    logic [1:0]           s1_opcode_reg;
    logic [VALUE_W-1:0]   s1_value_reg;

    // block state
    digits_t              digits_reg;
    digits_t              digits_next;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     pos_next;

    // output register
    logic                 out_valid_reg;
    logic                 strobe_valid_reg;
    logic [1:0]           strobe_line_reg;
    logic                 send_valid_reg;
    logic [SEG_W-1:0]     send_byte_reg;

    // stage 1 results
    logic                 has_result;
    logic                 res_strobe_valid;
    logic [1:0]           res_strobe_line;
    logic                 res_send_valid;
    logic [SEG_W-1:0]     res_send_byte;
    logic [1:0]           pos_clamped;
    logic [POS_W-1:0]     pos_inc;
    logic                 s1_go;
    logic                 in_take;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[3] == REG_PATTERNS_HIGH)
                       ? {{(PDATA_W-PATTERN_W){1'b0}}, pat_high_reg}
                       : {{(PDATA_W-PATTERN_W){1'b0}}, pat_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= PATTERNS_LOW_RST;
            pat_high_reg <= PATTERNS_HIGH_RST;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == REG_PATTERNS_HIGH)
                pat_high_reg <= pwdata[PATTERN_W-1:0];
            else
                pat_low_reg  <= pwdata[PATTERN_W-1:0];
        end
    end

    // stage 1 moves on when its word makes no result or the output slot frees
    assign s1_go    = s1_valid_reg && (!has_result || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_opcode_reg <= opcode;
            s1_value_reg  <= value;
        end
    end

    // position past the last digit cannot occur; clamp to the last one
    assign pos_clamped = (pos_reg > POS_W'(DIGIT_COUNT - 1)) ? 2'(DIGIT_COUNT - 1)
                                                             : pos_reg[1:0];
    assign pos_inc     = POS_W'(pos_clamped) + POS_W'(1);

    always_comb
    begin
        digits_next      = digits_reg;
        pos_next         = pos_reg;
        has_result       = 1'b0;
        res_strobe_valid = 1'b0;
        res_strobe_line  = '0;
        res_send_valid   = 1'b0;
        res_send_byte    = '0;
        case (op_t'(s1_opcode_reg))
            OP_SET_VALUE:
            begin
                digits_next = split_value(s1_value_reg);
            end
            OP_FRAME_TICK:
            begin
                pos_next       = '0;
                has_result     = 1'b1;
                res_send_valid = 1'b1;
                res_send_byte  = segment_byte(digits_reg[0], pat_low_reg, pat_high_reg);
            end
            OP_BYTE_DONE:
            begin
                has_result       = 1'b1;
                res_strobe_valid = 1'b1;
                res_strobe_line  = pos_clamped;
                if (pos_inc >= POS_W'(DIGIT_COUNT))
                begin
                    pos_next = '0;
                end
                else
                begin
                    pos_next       = pos_inc;
                    res_send_valid = 1'b1;
                    res_send_byte  = segment_byte(digits_reg[pos_inc[1:0]],
                                                  pat_low_reg, pat_high_reg);
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg[0] <= 4'd0;
            digits_reg[1] <= 4'd1;
            digits_reg[2] <= 4'd2;
            digits_reg[3] <= 4'd3;
            pos_reg       <= '0;
        end
        else if (s1_go)
        begin
            digits_reg <= digits_next;
            pos_reg    <= pos_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && has_result)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && has_result)
        begin
            strobe_valid_reg <= res_strobe_valid;
            strobe_line_reg  <= res_strobe_line;
            send_valid_reg   <= res_send_valid;
            send_byte_reg    <= res_send_byte;
        end
    end

    assign out_valid    = out_valid_reg;
    assign strobe_valid = strobe_valid_reg;
    assign strobe_line  = strobe_line_reg;
    assign send_valid   = send_valid_reg;
    assign send_byte    = send_byte_reg;

endmodule
